@@ hw/rtl/bst_pkg.sv @@
// Shared types and constants of the bencode stream tokenizer.
// Used by bst_core, bst_out_queue and bencode_stream_tokenizer_top; no dependencies.
`default_nettype none

package bst_pkg;

	localparam int DEPTH_BITS  = 8;
	localparam int LENGTH_BITS = 32;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	localparam logic [7:0] MAX_DEPTH_RESET = 8'd255;

	// event codes
	localparam logic [2:0] EV_INTEGER    = 3'd0;
	localparam logic [2:0] EV_STR_HEADER = 3'd1;
	localparam logic [2:0] EV_STR_BYTE   = 3'd2;
	localparam logic [2:0] EV_LIST_BEGIN = 3'd3;
	localparam logic [2:0] EV_DICT_BEGIN = 3'd4;
	localparam logic [2:0] EV_END        = 3'd5;
	localparam logic [2:0] EV_ERROR      = 3'd6;

	// error codes
	localparam logic [2:0] ERR_NONE         = 3'd0;
	localparam logic [2:0] ERR_EXTRA_END    = 3'd1;
	localparam logic [2:0] ERR_BAD_LENGTH   = 3'd2;
	localparam logic [2:0] ERR_BAD_SEP      = 3'd3;
	localparam logic [2:0] ERR_BAD_INTEGER  = 3'd4;
	localparam logic [2:0] ERR_BAD_TERM     = 3'd5;
	localparam logic [2:0] ERR_UNTERMINATED = 3'd6;
	localparam logic [2:0] ERR_TOO_DEEP     = 3'd7;

	// characters
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// config register address bit (byte address / 4)
	localparam logic REG_MAX_DEPTH = 1'b0;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [63:0] value;
		logic [7:0]  depth;
		logic [2:0]  error_code;
		logic        document_done;
		logic        last_of_item;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		logic [OQ_AW:0] count;
		logic           full;
	} oq_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/bencode_stream_tokenizer_top.sv @@
// Results of a byte are registered in the result queue and reach the output behind any earlier results.
// Throughput: one byte per cycle; a byte with two results needs two output transfers,
// and input stalls while the four-entry result queue has fewer than two free entries.
// Reset (arst_n low): parser back to idle, queue empty, max_depth = 255.
// Depends on bst_pkg, bst_core, bst_out_queue.
`default_nettype none

module bencode_stream_tokenizer_top
	import bst_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_input,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       event_res,
	output logic [63:0]      value,
	output logic [7:0]       depth,
	output logic [2:0]       error_code,
	output logic             document_done,
	output logic             last_of_item,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic       max_depth_q;
	logic [7:0] max_depth_val_q;
	logic       fire;
	logic       pop;
	push_t      push;
	result_t    head;
	oq_status_t status;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_depth_val_q <= MAX_DEPTH_RESET;
			max_depth_q     <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_DEPTH) begin
				max_depth_val_q <= pwdata[7:0];
				max_depth_q     <= 1'b1;
			end
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_DEPTH) ? {24'd0, max_depth_val_q} : 32'd0;

	assign in_stall = status.full;
	assign fire     = in_valid && !in_stall;
	assign out_valid = status.count != '0;
	assign pop      = out_valid && !out_stall;

	bst_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.data_byte   (data_byte),
		.end_of_input(end_of_input),
		.max_depth   (max_depth_val_q),
		.push        (push)
	);

	bst_out_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.head  (head),
		.status(status)
	);

	assign event_res     = head.event_res;
	assign value         = head.value;
	assign depth         = head.depth;
	assign error_code    = head.error_code;
	assign document_done = head.document_done;
	assign last_of_item  = head.last_of_item;

	// queue never overfills
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.count <= (OQ_AW+1)'(OQ_DEPTH))
		else $error("result queue overflow");

	// error code present exactly on error events
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((event_res == EV_ERROR) == (error_code != ERR_NONE)))
		else $error("error code does not match event");

	// completion only at top level and never on a begin or error event
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && document_done |-> depth == 8'd0 && event_res != EV_ERROR
			&& event_res != EV_LIST_BEGIN && event_res != EV_DICT_BEGIN)
		else $error("document_done on wrong event");

	// a transfer in always finds room for two results
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> status.count <= (OQ_AW+1)'(OQ_DEPTH - 2))
		else $error("transfer in without queue room");

	// max_depth_q marks a register write happened; written value is kept
	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(psel && penable && pwrite) |=> $stable(max_depth_val_q) || !max_depth_q
			|| $past(psel && penable && pwrite))
		else $error("max_depth changed without a write");

endmodule

`default_nettype wire

@@ hw/rtl/bst_core.sv @@
// Tokenizer state machine: parses one byte per transfer, yields up to two results.
// Depends on bst_pkg.
`default_nettype none

module bst_core
	import bst_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_input,
	input  wire logic [7:0] max_depth,
	output push_t           push
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_STR  = 3'd2;
	localparam logic [2:0] PH_INT  = 3'd3;
	localparam logic [2:0] PH_DONE = 3'd4;
	localparam logic [2:0] PH_HALT = 3'd5;

	localparam logic [15:0] DEPTH_LIM = 16'((1 << DEPTH_BITS) - 1);

	logic [2:0]             phase_q, n_phase;
	logic [DEPTH_BITS-1:0]  nest_q, n_nest;
	logic [63:0]            acc_q, n_acc;
	logic [LENGTH_BITS-1:0] rem_q, n_rem;
	logic                   neg_q, n_neg;
	logic                   seen_q, n_seen;

	logic        is_digit;
	logic [3:0]  dval;
	logic [67:0] acc_next;
	logic [15:0] cap;
	result_t     r0, r1;
	logic        r0v, r1v;
	logic [2:0]  eoi_code;

	function automatic result_t mk(logic [2:0] ev, logic [63:0] val,
			logic [DEPTH_BITS-1:0] dep, logic [2:0] err, logic done);
		result_t r;
		r.event_res     = ev;
		r.value         = val;
		r.depth         = 8'(dep);
		r.error_code    = err;
		r.document_done = done;
		r.last_of_item  = 1'b0;
		return r;
	endfunction

	always_comb begin
		is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
		dval     = 4'(data_byte - CH_ZERO);
		// acc*10 + digit, wide enough to see overflow
		acc_next = (68'(acc_q) << 3) + (68'(acc_q) << 1) + 68'(dval);
		cap      = (16'(max_depth) < DEPTH_LIM) ? 16'(max_depth) : DEPTH_LIM;

		n_phase = phase_q;
		n_nest  = nest_q;
		n_acc   = acc_q;
		n_rem   = rem_q;
		n_neg   = neg_q;
		n_seen  = seen_q;
		r0v     = 1'b0;
		r0      = mk(EV_ERROR, 64'd0, nest_q, ERR_NONE, 1'b0);

		unique case (phase_q)
			PH_IDLE: begin
				if (is_digit) begin
					n_phase = PH_LEN;
					n_acc   = 64'(dval);
				end else if (data_byte == CH_I) begin
					n_phase = PH_INT;
					n_acc   = 64'd0;
					n_neg   = 1'b0;
					n_seen  = 1'b0;
				end else if (data_byte == CH_L || data_byte == CH_D) begin
					r0v = 1'b1;
					if (16'(nest_q) >= cap) begin
						r0      = mk(EV_ERROR, 64'd0, nest_q, ERR_TOO_DEEP, 1'b0);
						n_phase = PH_HALT;
					end else begin
						n_nest = nest_q + DEPTH_BITS'(1);
						r0     = mk((data_byte == CH_L) ? EV_LIST_BEGIN : EV_DICT_BEGIN,
							64'd0, n_nest, ERR_NONE, 1'b0);
					end
				end else if (data_byte == CH_E) begin
					r0v = 1'b1;
					if (nest_q != '0) begin
						n_nest  = nest_q - DEPTH_BITS'(1);
						n_phase = (n_nest == '0) ? PH_DONE : PH_IDLE;
						r0      = mk(EV_END, 64'd0, n_nest, ERR_NONE, n_nest == '0);
					end else begin
						r0      = mk(EV_ERROR, 64'd0, nest_q, ERR_EXTRA_END, 1'b0);
						n_phase = PH_HALT;
					end
				end else if (nest_q != '0) begin
					r0v     = 1'b1;
					r0      = mk(EV_ERROR, 64'd0, nest_q, ERR_UNTERMINATED, 1'b0);
					n_phase = PH_HALT;
				end else begin
					n_phase = PH_HALT;
				end
			end
			PH_LEN: begin
				if (is_digit) begin
					if ((acc_next >> LENGTH_BITS) != '0) begin
						r0v     = 1'b1;
						r0      = mk(EV_ERROR, 64'd0, nest_q, ERR_BAD_LENGTH, 1'b0);
						n_phase = PH_HALT;
					end else begin
						n_acc = acc_next[63:0];
					end
				end else if (data_byte == CH_COLON) begin
					r0v   = 1'b1;
					n_rem = acc_q[LENGTH_BITS-1:0];
					n_acc = 64'd0;
					if (acc_q == 64'd0) begin
						n_phase = (nest_q == '0) ? PH_DONE : PH_IDLE;
						r0      = mk(EV_STR_HEADER, 64'd0, nest_q, ERR_NONE, nest_q == '0);
					end else begin
						n_phase = PH_STR;
						r0      = mk(EV_STR_HEADER, 64'(acc_q[LENGTH_BITS-1:0]), nest_q,
							ERR_NONE, 1'b0);
					end
				end else begin
					r0v     = 1'b1;
					r0      = mk(EV_ERROR, 64'd0, nest_q, ERR_BAD_SEP, 1'b0);
					n_phase = PH_HALT;
				end
			end
			PH_STR: begin
				r0v   = 1'b1;
				n_rem = rem_q - LENGTH_BITS'(1);
				if (n_rem == '0) begin
					n_phase = (nest_q == '0) ? PH_DONE : PH_IDLE;
					r0      = mk(EV_STR_BYTE, 64'(data_byte), nest_q, ERR_NONE, nest_q == '0);
				end else begin
					r0 = mk(EV_STR_BYTE, 64'(data_byte), nest_q, ERR_NONE, 1'b0);
				end
			end
			PH_INT: begin
				if (is_digit) begin
					if (acc_next[67:64] != 4'd0) begin
						r0v     = 1'b1;
						r0      = mk(EV_ERROR, 64'd0, nest_q, ERR_BAD_INTEGER, 1'b0);
						n_phase = PH_HALT;
					end else begin
						n_acc  = acc_next[63:0];
						n_seen = 1'b1;
					end
				end else if (data_byte == CH_MINUS && !seen_q && !neg_q) begin
					n_neg = 1'b1;
				end else if (!seen_q) begin
					r0v     = 1'b1;
					r0      = mk(EV_ERROR, 64'd0, nest_q, ERR_BAD_INTEGER, 1'b0);
					n_phase = PH_HALT;
				end else if (data_byte == CH_E) begin
					r0v     = 1'b1;
					n_phase = (nest_q == '0) ? PH_DONE : PH_IDLE;
					r0      = mk(EV_INTEGER, neg_q ? (64'd0 - acc_q) : acc_q, nest_q,
						ERR_NONE, nest_q == '0);
				end else begin
					r0v     = 1'b1;
					r0      = mk(EV_ERROR, 64'd0, nest_q, ERR_BAD_TERM, 1'b0);
					n_phase = PH_HALT;
				end
			end
			default: begin
			end
		endcase

		// end of input: termination check on the updated state, then re-arm
		eoi_code = ERR_NONE;
		if (end_of_input) begin
			unique case (n_phase)
				PH_IDLE: eoi_code = (n_nest != '0) ? ERR_UNTERMINATED : ERR_NONE;
				PH_LEN:  eoi_code = ERR_BAD_SEP;
				PH_STR:  eoi_code = ERR_UNTERMINATED;
				PH_INT:  eoi_code = n_seen ? ERR_BAD_TERM : ERR_BAD_INTEGER;
				default: eoi_code = ERR_NONE;
			endcase
		end
		r1v = (eoi_code != ERR_NONE);
		r1  = mk(EV_ERROR, 64'd0, n_nest, eoi_code, 1'b0);
		r1.last_of_item = 1'b1;
		if (end_of_input) begin
			n_phase = PH_IDLE;
			n_nest  = '0;
			n_acc   = 64'd0;
			n_rem   = '0;
			n_neg   = 1'b0;
			n_seen  = 1'b0;
		end

		r0.last_of_item = !r1v;
		push.cnt = fire ? (2'(r0v) + 2'(r1v)) : 2'd0;
		push.r0  = r0v ? r0 : r1;
		push.r1  = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			nest_q  <= '0;
			acc_q   <= 64'd0;
			rem_q   <= '0;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= n_phase;
			nest_q  <= n_nest;
			acc_q   <= n_acc;
			rem_q   <= n_rem;
			neg_q   <= n_neg;
			seen_q  <= n_seen;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/bst_out_queue.sv @@
// Result queue: takes up to two results per cycle, delivers one per transfer.
// Depends on bst_pkg.
`default_nettype none

module bst_out_queue
	import bst_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	input  wire logic  pop,
	output result_t    head,
	output oq_status_t status
);

	result_t          mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_q, rd_q;
	logic [OQ_AW:0]   count_q;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_q + OQ_AW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + OQ_AW'(push.cnt);
			rd_q    <= rd_q + OQ_AW'(pop);
			count_q <= count_q + (OQ_AW+1)'(push.cnt) - (OQ_AW+1)'(pop);
		end
	end

	assign head         = mem_q[rd_q];
	assign status.count = count_q;
	// room for a two-result item is needed before the next transfer in
	assign status.full  = count_q > (OQ_AW+1)'(OQ_DEPTH - 2);

endmodule

`default_nettype wire
